// ===== rtl/core/bcd_pkg.sv =====
`default_nettype none

package bcd_pkg;

  localparam int CNT_W       = 13;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Register map, one 32-bit word per register.
  typedef enum logic [2:0] {
    REG_DIFF_THR  = 3'd0,
    REG_COUNT_THR = 3'd1,
    REG_BLOCK_SZ  = 3'd2,
    REG_WIDTH_BLK = 3'd3,
    REG_HEIGHT_BLK = 3'd4
  } cfg_reg_t;

  localparam logic [7:0]       RST_DIFF_THR   = 8'd20;
  localparam logic [CNT_W-1:0] RST_COUNT_THR  = 13'd64;
  localparam logic [6:0]       RST_BLOCK_SZ   = 7'd8;
  localparam logic [8:0]       RST_WIDTH_BLK  = 9'd80;
  localparam logic [8:0]       RST_HEIGHT_BLK = 9'd60;

  // Effective settings, already clamped to legal ranges; geometry is stored
  // as "limit minus one" so that last-position checks are plain compares.
  typedef struct packed {
    logic [7:0]       diff_thr;
    logic [CNT_W-1:0] count_thr;
    logic [5:0]       bs_m1;
    logic [7:0]       wb_m1;
    logic [7:0]       hb_m1;
  } cfg_t;

  // One classified pixel on its way from the front to the counting stage.
  typedef struct packed {
    logic [7:0] col;
    logic [7:0] row;
    logic       first;
    logic       inc;
    logic       emit;
    logic       frame_done;
  } item_t;

endpackage

`default_nettype wire

// ===== rtl/core/bcd_if.sv =====
`default_nettype none

interface bcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] new_pixel;
  logic [7:0] background_pixel;
  logic       frame_start;

  modport source (output valid, new_pixel, background_pixel, frame_start, input ready);
  modport sink   (input valid, new_pixel, background_pixel, frame_start, output ready);
endinterface

interface bcd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] block_col;
  logic [7:0] block_row;
  logic       changed;
  logic       frame_done;

  modport source (output valid, block_col, block_row, changed, frame_done, input ready);
  modport sink   (input valid, block_col, block_row, changed, frame_done, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/block_change_detector_top.sv =====
// An accepted word passes through the queue and the back-end stage register;
// a word that closes a block then loads the output register when it is free.
// Throughput: one pixel pair per clock (one count read and one count write
// per cycle); a stalled output holds the input once the four-word queue fills.
// Reset: synchronous, active low; registers take their defaults, the position
// and queue are cleared and every column count reads as zero.
`default_nettype none

module block_change_detector_top #(
  parameter int MAX_BLOCK_COLS = 256,
  parameter int MAX_BLOCK_SIZE = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  bcd_in_if.sink                      in_ch,
  bcd_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bcd_pkg::ADDR_W-1:0]  paddr,
  input  logic [bcd_pkg::DATA_W-1:0]  pwdata,
  output logic [bcd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import bcd_pkg::*;

  cfg_t  cfg;
  item_t push_item, head_item;
  logic  push, q_full, pop, head_valid;

  // Register file; settings leave it already clamped to legal ranges.
  bcd_regs #(
    .MAX_BLOCK_COLS (MAX_BLOCK_COLS),
    .MAX_BLOCK_SIZE (MAX_BLOCK_SIZE)
  ) u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The front tracks the raster position and classifies each pixel: which
  // block column it belongs to, whether it opens or closes a block and
  // whether its difference counts as changed.
  bcd_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg    (cfg),
    .q_full (q_full),
    .push   (push),
    .item   (push_item)
  );

  // A short queue lets the front keep taking words while the back end
  // waits on a stalled output.
  bcd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  // The back end updates the per-column count memory with forwarding for
  // back-to-back pixels of one block, and registers each block result.
  bcd_back #(
    .MAX_BLOCK_COLS (MAX_BLOCK_COLS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .count_thr  (cfg.count_thr),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

// ===== rtl/core/bcd_regs.sv =====
`default_nettype none

module bcd_regs #(
  parameter int MAX_BLOCK_COLS = 256,
  parameter int MAX_BLOCK_SIZE = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bcd_pkg::ADDR_W-1:0]  paddr,
  input  logic [bcd_pkg::DATA_W-1:0]  pwdata,
  output logic [bcd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output bcd_pkg::cfg_t               cfg
);
  import bcd_pkg::*;

  localparam int LIM_BS = (MAX_BLOCK_SIZE < 64) ? MAX_BLOCK_SIZE : 64;
  localparam int LIM_W  = (MAX_BLOCK_COLS < 256) ? MAX_BLOCK_COLS : 256;

  logic [7:0]       diff_thr_r;
  logic [CNT_W-1:0] count_thr_r;
  logic [6:0]       block_sz_r;
  logic [8:0]       width_blk_r;
  logic [8:0]       height_blk_r;
  logic             wr_en;
  cfg_reg_t         sel;

  assign pready = 1'b1;
  assign sel    = cfg_reg_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diff_thr_r   <= RST_DIFF_THR;
      count_thr_r  <= RST_COUNT_THR;
      block_sz_r   <= RST_BLOCK_SZ;
      width_blk_r  <= RST_WIDTH_BLK;
      height_blk_r <= RST_HEIGHT_BLK;
    end else if (wr_en) begin
      case (sel)
        REG_DIFF_THR:   diff_thr_r   <= pwdata[7:0];
        REG_COUNT_THR:  count_thr_r  <= pwdata[CNT_W-1:0];
        REG_BLOCK_SZ:   block_sz_r   <= pwdata[6:0];
        REG_WIDTH_BLK:  width_blk_r  <= pwdata[8:0];
        REG_HEIGHT_BLK: height_blk_r <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_DIFF_THR:   prdata = {{(DATA_W-8){1'b0}}, diff_thr_r};
      REG_COUNT_THR:  prdata = {{(DATA_W-CNT_W){1'b0}}, count_thr_r};
      REG_BLOCK_SZ:   prdata = {{(DATA_W-7){1'b0}}, block_sz_r};
      REG_WIDTH_BLK:  prdata = {{(DATA_W-9){1'b0}}, width_blk_r};
      REG_HEIGHT_BLK: prdata = {{(DATA_W-9){1'b0}}, height_blk_r};
      default:        prdata = '0;
    endcase
  end

  // Zero is treated as one and values above the limit as the limit.
  always_comb begin
    cfg.diff_thr  = diff_thr_r;
    cfg.count_thr = count_thr_r;

    if (block_sz_r == 7'd0) begin
      cfg.bs_m1 = 6'd0;
    end else if (block_sz_r > 7'(LIM_BS)) begin
      cfg.bs_m1 = 6'(LIM_BS - 1);
    end else begin
      cfg.bs_m1 = 6'(block_sz_r - 7'd1);
    end

    if (width_blk_r == 9'd0) begin
      cfg.wb_m1 = 8'd0;
    end else if (width_blk_r > 9'(LIM_W)) begin
      cfg.wb_m1 = 8'(LIM_W - 1);
    end else begin
      cfg.wb_m1 = 8'(width_blk_r - 9'd1);
    end

    if (height_blk_r == 9'd0) begin
      cfg.hb_m1 = 8'd0;
    end else if (height_blk_r > 9'd256) begin
      cfg.hb_m1 = 8'd255;
    end else begin
      cfg.hb_m1 = 8'(height_blk_r - 9'd1);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bcd_front.sv =====
`default_nettype none

module bcd_front (
  input  logic          clk,
  input  logic          rst_n,
  bcd_in_if.sink        in_ch,
  input  bcd_pkg::cfg_t cfg,
  input  logic          q_full,
  output logic          push,
  output bcd_pkg::item_t item
);
  import bcd_pkg::*;

  logic [5:0] x_r, x_nxt, x_cur;
  logic [5:0] y_r, y_nxt, y_cur;
  logic [7:0] col_r, col_nxt, col_cur;
  logic [7:0] row_r, row_nxt, row_cur;
  logic [7:0] diff;
  logic       last_x, last_y, last_col, last_row;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && in_ch.ready;

  always_comb begin
    // A frame start moves the position back to the first pixel before use.
    x_cur   = in_ch.frame_start ? 6'd0 : x_r;
    y_cur   = in_ch.frame_start ? 6'd0 : y_r;
    col_cur = in_ch.frame_start ? 8'd0 : col_r;
    row_cur = in_ch.frame_start ? 8'd0 : row_r;

    diff = (in_ch.new_pixel >= in_ch.background_pixel)
         ? in_ch.new_pixel - in_ch.background_pixel
         : in_ch.background_pixel - in_ch.new_pixel;

    last_x   = x_cur >= cfg.bs_m1;
    last_y   = y_cur >= cfg.bs_m1;
    last_col = col_cur >= cfg.wb_m1;
    last_row = row_cur >= cfg.hb_m1;

    item.col        = col_cur;
    item.row        = row_cur;
    item.first      = (x_cur == 6'd0) && (y_cur == 6'd0);
    item.inc        = diff >= cfg.diff_thr;
    item.emit       = last_x && last_y;
    item.frame_done = last_col && last_row;

    x_nxt   = x_cur;
    y_nxt   = y_cur;
    col_nxt = col_cur;
    row_nxt = row_cur;
    if (!last_x) begin
      x_nxt = x_cur + 6'd1;
    end else begin
      x_nxt = 6'd0;
      if (!last_col) begin
        col_nxt = col_cur + 8'd1;
      end else begin
        col_nxt = 8'd0;
        if (!last_y) begin
          y_nxt = y_cur + 6'd1;
        end else begin
          y_nxt   = 6'd0;
          row_nxt = last_row ? 8'd0 : row_cur + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r   <= '0;
      y_r   <= '0;
      col_r <= '0;
      row_r <= '0;
    end else if (push) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bcd_queue.sv =====
`default_nettype none

module bcd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bcd_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output bcd_pkg::item_t head_item
);
  import bcd_pkg::*;

  item_t            slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  assign full       = count_r == (QPTR_W+1)'(QUEUE_DEPTH);
  assign head_valid = count_r != '0;
  assign head_item  = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + (QPTR_W+1)'(1);
        2'b01:   count_r <= count_r - (QPTR_W+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bcd_back.sv =====
`default_nettype none

module bcd_back #(
  parameter int MAX_BLOCK_COLS = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [bcd_pkg::CNT_W-1:0]    count_thr,
  input  logic                         head_valid,
  input  bcd_pkg::item_t               head_item,
  output logic                         pop,
  bcd_out_if.source                    out_ch
);
  import bcd_pkg::*;

  localparam int DEPTH = (MAX_BLOCK_COLS < 256) ? MAX_BLOCK_COLS : 256;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CNT_W-1:0] count_mem [DEPTH];
  logic [DEPTH-1:0] vld_r;

  item_t            a_item_r;
  logic             a_valid_r;
  logic [CNT_W-1:0] rd_cnt_r;
  logic             rd_vld_r;

  logic [IDX_W-1:0] wr_slot_r;
  logic [CNT_W-1:0] wr_val_r;
  logic             wr_vld_r;

  logic             out_valid_r;
  logic [7:0]       out_col_r, out_row_r;
  logic             out_changed_r, out_done_r;

  logic [IDX_W-1:0] a_slot, head_slot;
  logic [CNT_W-1:0] base_cnt, new_cnt;
  logic             out_free, a_fire, fwd_hit;

  assign head_slot = head_item.col[IDX_W-1:0];
  assign a_slot    = a_item_r.col[IDX_W-1:0];
  assign out_free  = !out_valid_r || out_ch.ready;
  assign a_fire    = a_valid_r && (!a_item_r.emit || out_free);
  assign pop       = head_valid && (!a_valid_r || a_fire);

  // The read issued on entry misses a write made on the same edge; the
  // last written count is kept and used instead when the column matches.
  assign fwd_hit = wr_vld_r && (wr_slot_r == a_slot);

  always_comb begin
    if (a_item_r.first) begin
      base_cnt = '0;
    end else if (fwd_hit) begin
      base_cnt = wr_val_r;
    end else if (rd_vld_r) begin
      base_cnt = rd_cnt_r;
    end else begin
      base_cnt = '0;
    end
    new_cnt = (a_item_r.inc && base_cnt != CNT_MAX) ? base_cnt + CNT_W'(1) : base_cnt;
  end

  always_ff @(posedge clk) begin
    if (a_fire) begin
      count_mem[a_slot] <= new_cnt;
    end
    if (pop) begin
      rd_cnt_r <= count_mem[head_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_item_r <= head_item;
      rd_vld_r <= vld_r[head_slot];
    end
    if (a_fire) begin
      wr_slot_r <= a_slot;
      wr_val_r  <= new_cnt;
    end
    if (a_fire && a_item_r.emit) begin
      out_col_r     <= a_item_r.col;
      out_row_r     <= a_item_r.row;
      out_changed_r <= new_cnt >= count_thr;
      out_done_r    <= a_item_r.frame_done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      a_valid_r   <= 1'b0;
      wr_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (a_fire) begin
        vld_r[a_slot] <= 1'b1;
        wr_vld_r      <= 1'b1;
      end
      if (pop) begin
        a_valid_r <= 1'b1;
      end else if (a_fire) begin
        a_valid_r <= 1'b0;
      end
      if (a_fire && a_item_r.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.block_col  = out_col_r;
  assign out_ch.block_row  = out_row_r;
  assign out_ch.changed    = out_changed_r;
  assign out_ch.frame_done = out_done_r;

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bcd_pkg::*;

  // Cycles to let pass once the last expected block result has come back.
  // A pixel word passes through the queue, the stage register and the output
  // register. Words that close no block produce nothing, so the pipeline is
  // given this much room before any register is touched.
  localparam int SETTLE_CYCLES = 4;
  // Upper bound on the wait for outstanding results before they are
  // declared lost.
  localparam int DRAIN_LIMIT = 5000;
  // A full run is about 1.2k pixel words, each with a bounded sender gap and
  // receiver stall, plus register traffic and drains. The limit leaves many
  // times the length of such a run, enough even if every drain runs into its
  // own limit.
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int RANDOM_ITEMS = 300;
  localparam int MAX_SHOWN = 10;

  // How busy a side of the stream is: never idle, sometimes idle, or
  // frequently idle.
  typedef enum int {
    IDLE_NONE,
    IDLE_LIGHT,
    IDLE_HEAVY
  } idle_mode_t;

  // One finished block as it leaves the block.
  typedef struct packed {
    logic [7:0] col;
    logic [7:0] row;
    logic       changed;
    logic       frame_done;
  } blk_result_t;

  logic clk;
  logic rst_n;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  bcd_in_if  in_ch ();
  bcd_out_if out_ch ();

  block_change_detector_top u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Copy of the register file as the block should see it. Values are kept
  // exactly as written (masked to the register width); clamping to the
  // legal ranges happens where they are used.
  logic [7:0]       thr_diff    = RST_DIFF_THR;
  logic [CNT_W-1:0] thr_count   = RST_COUNT_THR;
  logic [6:0]       blk_size    = RST_BLOCK_SZ;
  logic [8:0]       blocks_wide = RST_WIDTH_BLK;
  logic [8:0]       blocks_high = RST_HEIGHT_BLK;

  // Raster position and the changed-pixel count of each block column.
  logic [5:0]       pos_x   = '0;
  logic [5:0]       pos_y   = '0;
  logic [7:0]       pos_col = '0;
  logic [7:0]       pos_row = '0;
  logic [CNT_W-1:0] col_count [256];

  // Block results that the accepted pixel words have promised, oldest first.
  blk_result_t pending_blocks [$];

  int         error_count  = 0;
  int         cycle_count  = 0;
  int         pixels_sent  = 0;
  int         ready_hold   = 0;
  idle_mode_t in_mode      = IDLE_NONE;
  idle_mode_t out_mode     = IDLE_NONE;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // A hard stop in case the block hangs or drops a handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic void flag_error(string msg);
    error_count++;
    if (error_count <= MAX_SHOWN) $display("%0t: %s", $realtime, msg);
  endfunction

  function automatic int limit_range(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Number of pixel words in one full frame under the current settings.
  function automatic int frame_pixels();
    int bs;
    bs = limit_range(int'(blk_size), 64);
    return bs * bs * limit_range(int'(blocks_wide), 256) *
           limit_range(int'(blocks_high), 256);
  endfunction

  // Length of the next idle stretch. Most gaps are short, a few are long,
  // and the no-idle mode gives runs of back-to-back words.
  function automatic int pick_gap(idle_mode_t mode);
    int r;
    r = $urandom_range(99);
    if (mode == IDLE_NONE) return 0;
    if (mode == IDLE_LIGHT) begin
      if (r < 80) return 0;
      if (r < 97) return $urandom_range(3, 1);
      return $urandom_range(20, 5);
    end
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(20, 5);
  endfunction

  // Follows one accepted pixel word through the block: clears the column
  // count on the first pixel of a block, counts the pixel if its difference
  // reaches the threshold, queues a result on the last pixel of a block, and
  // then steps the raster position. Positions left beyond a limit that was
  // lowered mid-frame are treated as the last one of their dimension.
  function automatic void track_pixel(logic [7:0] np, logic [7:0] bp, logic fs);
    int          bs;
    int          wb;
    int          hb;
    int          diff;
    bit          last_x;
    bit          last_y;
    bit          last_col;
    bit          last_row;
    blk_result_t res;
    bs = limit_range(int'(blk_size), 64);
    wb = limit_range(int'(blocks_wide), 256);
    hb = limit_range(int'(blocks_high), 256);
    if (fs) begin
      pos_x   = '0;
      pos_y   = '0;
      pos_col = '0;
      pos_row = '0;
    end
    if (pos_x == 0 && pos_y == 0) col_count[pos_col] = '0;
    diff = (np >= bp) ? int'(np) - int'(bp) : int'(bp) - int'(np);
    if (diff >= int'(thr_diff) && col_count[pos_col] != CNT_MAX) col_count[pos_col]++;
    last_x   = int'(pos_x) + 1 >= bs;
    last_y   = int'(pos_y) + 1 >= bs;
    last_col = int'(pos_col) + 1 >= wb;
    last_row = int'(pos_row) + 1 >= hb;
    if (last_x && last_y) begin
      res.col        = pos_col;
      res.row        = pos_row;
      res.changed    = col_count[pos_col] >= thr_count;
      res.frame_done = last_col && last_row;
      pending_blocks.push_back(res);
    end
    if (!last_x) begin
      pos_x++;
    end else begin
      pos_x = '0;
      if (!last_col) begin
        pos_col++;
      end else begin
        pos_col = '0;
        if (!last_y) begin
          pos_y++;
        end else begin
          pos_y = '0;
          if (!last_row) pos_row++;
          else pos_row = '0;
        end
      end
    end
  endfunction

  // Both channels are observed at the rising edge, before the block updates
  // anything. Input words are predicted first so that a result is always
  // matched against a prediction made no later than the same edge.
  always @(posedge clk) begin : score_blk
    blk_result_t got;
    blk_result_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        track_pixel(in_ch.new_pixel, in_ch.background_pixel, in_ch.frame_start);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.col        = out_ch.block_col;
        got.row        = out_ch.block_row;
        got.changed    = out_ch.changed;
        got.frame_done = out_ch.frame_done;
        if (pending_blocks.size() == 0) begin
          flag_error($sformatf("unexpected block result: col %0d row %0d changed %0b done %0b",
                               got.col, got.row, got.changed, got.frame_done));
        end else begin
          want = pending_blocks.pop_front();
          if (got.col !== want.col || got.row !== want.row ||
              got.changed !== want.changed || got.frame_done !== want.frame_done) begin
            flag_error($sformatf({"block result mismatch: expected col %0d row %0d changed %0b ",
                                  "done %0b, got col %0d row %0d changed %0b done %0b"},
                                 want.col, want.row, want.changed, want.frame_done,
                                 got.col, got.row, got.changed, got.frame_done));
          end
        end
      end
    end
  end

  // The result side stalls in random stretches. Ready goes high again between
  // stalls, so no stall can last forever.
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      out_ch.ready <= 1'b0;
      ready_hold--;
    end else begin
      out_ch.ready <= 1'b1;
      ready_hold = pick_gap(out_mode);
    end
  end

  // All bus and stream tasks start and end at a falling edge. A word stays
  // on the bus until it is accepted. Valid is left high on return so that a
  // following word goes out back to back; whoever calls next either drives
  // a new word or lowers valid in the same time step.
  task automatic send_pixel(logic [7:0] np, logic [7:0] bp, logic fs);
    int gap;
    gap = pick_gap(in_mode);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.new_pixel        <= np;
    in_ch.background_pixel <= bp;
    in_ch.frame_start      <= fs;
    do @(posedge clk); while (!in_ch.ready);
    pixels_sent++;
    @(negedge clk);
  endtask

  // Lowers valid and waits until every promised block result has come back,
  // then lets the pipeline settle. Anything still missing counts as lost.
  task automatic wait_drained();
    int waited;
    in_ch.valid <= 1'b0;
    waited = 0;
    while (pending_blocks.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    while (pending_blocks.size() != 0) begin
      want_lost(pending_blocks.pop_front());
    end
  endtask

  function automatic void want_lost(blk_result_t want);
    flag_error($sformatf("missing block result: col %0d row %0d changed %0b done %0b",
                         want.col, want.row, want.changed, want.frame_done));
  endfunction

  // Register read with a setup and an access phase. The value is taken at
  // the edge that completes the access.
  task automatic check_reg(cfg_reg_t idx, logic [DATA_W-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      flag_error($sformatf("register %s reads %0d, expected %0d", idx.name(), prdata, want));
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Register write, followed by a read back of the same register. The local
  // copy changes at the very edge at which the block takes the value.
  task automatic write_reg(cfg_reg_t idx, int unsigned val);
    logic [DATA_W-1:0] stored;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_DIFF_THR:   thr_diff    = val[7:0];
      REG_COUNT_THR:  thr_count   = val[CNT_W-1:0];
      REG_BLOCK_SZ:   blk_size    = val[6:0];
      REG_WIDTH_BLK:  blocks_wide = val[8:0];
      REG_HEIGHT_BLK: blocks_high = val[8:0];
      default: ;
    endcase
    case (idx)
      REG_DIFF_THR:   stored = DATA_W'(thr_diff);
      REG_COUNT_THR:  stored = DATA_W'(thr_count);
      REG_BLOCK_SZ:   stored = DATA_W'(blk_size);
      REG_WIDTH_BLK:  stored = DATA_W'(blocks_wide);
      default:        stored = DATA_W'(blocks_high);
    endcase
    @(negedge clk);
    check_reg(idx, stored);
  endtask

  task automatic set_geometry(int bs, int wb, int hb);
    write_reg(REG_BLOCK_SZ, bs);
    write_reg(REG_WIDTH_BLK, wb);
    write_reg(REG_HEIGHT_BLK, hb);
  endtask

  task automatic set_thresholds(int diff, int count);
    write_reg(REG_DIFF_THR, diff);
    write_reg(REG_COUNT_THR, count);
  endtask

  // Random pixel pair. A good share lands right around the difference
  // threshold or has no difference at all, since those decide the count.
  function automatic void next_pair(output logic [7:0] np, output logic [7:0] bp);
    int d;
    int v;
    bp = 8'($urandom_range(255));
    np = 8'($urandom_range(255));
    case ($urandom_range(3))
      2: begin
        d = int'(thr_diff) + int'($urandom_range(2)) - 1;
        if (d < 0) d = 0;
        v = $urandom_range(1) ? int'(bp) + d : int'(bp) - d;
        if (v < 0 || v > 255) v = 2 * int'(bp) - v;
        if (v >= 0 && v <= 255) np = 8'(v);
      end
      3: np = bp;
      default: ;
    endcase
  endfunction

  // Sends n random pixel words; the word with index start_at carries the
  // frame start flag (pass -1 for none).
  task automatic send_stream(int n, int start_at);
    logic [7:0] np;
    logic [7:0] bp;
    for (int i = 0; i < n; i++) begin
      next_pair(np, bp);
      send_pixel(np, bp, i == start_at);
    end
  endtask

  // Fixed pairs at the corners of the pixel range, on both sides of a
  // threshold of 20, and with alternating bit patterns.
  function automatic logic [15:0] edge_pair(int i);
    case (i % 10)
      0: return {8'd0, 8'd255};
      1: return {8'd255, 8'd0};
      2: return {8'd0, 8'd0};
      3: return {8'd255, 8'd255};
      4: return {8'd100, 8'd80};
      5: return {8'd80, 8'd100};
      6: return {8'd100, 8'd81};
      7: return {8'd81, 8'd100};
      8: return {8'hAA, 8'h55};
      default: return {8'h55, 8'hAA};
    endcase
  endfunction

  task automatic send_edge_run(int n, int start_at, int first);
    logic [15:0] p;
    for (int i = 0; i < n; i++) begin
      p = edge_pair(first + i);
      send_pixel(p[15:8], p[7:0], i == start_at);
    end
  endtask

  // All registers must come out of reset at their documented defaults.
  task automatic test_register_defaults();
    check_reg(REG_DIFF_THR, DATA_W'(RST_DIFF_THR));
    check_reg(REG_COUNT_THR, DATA_W'(RST_COUNT_THR));
    check_reg(REG_BLOCK_SZ, DATA_W'(RST_BLOCK_SZ));
    check_reg(REG_WIDTH_BLK, DATA_W'(RST_WIDTH_BLK));
    check_reg(REG_HEIGHT_BLK, DATA_W'(RST_HEIGHT_BLK));
  endtask

  // A short hand-built stream on a two-block frame: one frame with a start
  // flag, a second frame that simply runs on past the end of the first, and
  // a restart flag that arrives in the middle of a block.
  task automatic test_directed_words();
    in_mode  = IDLE_NONE;
    out_mode = IDLE_NONE;
    set_thresholds(20, 2);
    set_geometry(2, 2, 1);
    for (int i = 0; i < 27; i++) begin
      send_edge_run(1, (i == 0 || i == 19) ? 0 : -1, i);
    end
    wait_drained();
  endtask

  // Threshold corners: a zero count threshold marks every block, the largest
  // difference threshold only counts black against white, a zero difference
  // threshold counts every pixel, and an unreachable count marks nothing.
  task automatic test_threshold_extremes();
    in_mode  = IDLE_LIGHT;
    out_mode = IDLE_HEAVY;
    set_geometry(1, 4, 2);
    set_thresholds(255, 0);
    send_edge_run(8, 0, 2);
    wait_drained();
    set_thresholds(255, 1);
    send_edge_run(10, 0, 0);
    wait_drained();
    set_thresholds(0, 1);
    send_stream(8, 0);
    wait_drained();
    set_geometry(2, 2, 1);
    set_thresholds(0, 4096);
    send_stream(8, 0);
    wait_drained();
    set_thresholds(128, 4);
    send_edge_run(8, 0, 8);
    wait_drained();
  endtask

  // Geometry corners, including zero and oversized register values that the
  // block must clamp, and an oversized block size that must clamp to the
  // largest block.
  task automatic test_size_limits();
    in_mode  = IDLE_LIGHT;
    out_mode = IDLE_LIGHT;
    set_thresholds(30, 1);
    set_geometry(0, 2, 2);
    send_stream(frame_pixels(), 0);
    wait_drained();
    set_geometry(1, 511, 1);
    send_stream(frame_pixels(), 0);
    wait_drained();
    set_geometry(1, 0, 3);
    send_stream(frame_pixels(), 0);
    wait_drained();
    set_geometry(1, 1, 511);
    send_stream(frame_pixels(), 0);
    wait_drained();
    set_geometry(1, 3, 0);
    send_stream(frame_pixels(), 0);
    wait_drained();

    // An oversized block size clamps to 64, so after 70 words the position
    // sits six pixels into the second block column. Dropping to one-pixel
    // blocks then closes that block at once and wraps to the frame start.
    set_geometry(127, 2, 1);
    send_stream(70, 0);
    wait_drained();
    set_geometry(1, 2, 1);
    send_stream(3, -1);
    wait_drained();
  endtask

  // The geometry shrinks and grows while a frame is half done, so that the
  // position sits at or beyond the new limits and must wrap on its next step.
  task automatic test_midframe_reconfig();
    in_mode  = IDLE_HEAVY;
    out_mode = IDLE_LIGHT;
    set_thresholds(25, 3);
    set_geometry(4, 3, 2);
    send_stream(37, 0);
    wait_drained();
    set_geometry(2, 1, 2);
    send_stream(20, -1);
    wait_drained();
    set_geometry(3, 4, 1);
    send_stream(30, -1);
    wait_drained();
    set_geometry(1, 2, 1);
    send_stream(5, -1);
    wait_drained();
    repeat (4) begin
      set_geometry($urandom_range(5, 1), $urandom_range(4, 1), $urandom_range(3, 1));
      send_stream($urandom_range(40, 1), -1);
      wait_drained();
    end
  endtask

  // Random settings, one per phase, each followed by a few frames. Most
  // frames are complete and start with the flag; the rest are cut short,
  // restart in the middle, or run on without a flag.
  task automatic test_random_frames();
    int base;
    int bs;
    int len;
    int kind;
    base = pixels_sent;
    while (pixels_sent - base < RANDOM_ITEMS) begin
      bs = ($urandom_range(9) == 0) ? $urandom_range(8, 5) : $urandom_range(4, 1);
      if (bs > 4) set_geometry(bs, $urandom_range(2, 1), $urandom_range(2, 1));
      else set_geometry(bs, $urandom_range(6, 1), $urandom_range(4, 1));
      set_thresholds($urandom_range(1) ? $urandom_range(40) : $urandom_range(255),
                     $urandom_range(bs * bs + 1, 0));
      in_mode  = idle_mode_t'($urandom_range(2));
      out_mode = idle_mode_t'($urandom_range(2));
      repeat ($urandom_range(3, 1)) begin
        len  = frame_pixels();
        kind = $urandom_range(9);
        if (kind < 7) send_stream(len, 0);
        else if (kind == 7) send_stream($urandom_range(len, 1), 0);
        else if (kind == 8) send_stream(len, (len > 1) ? $urandom_range(len - 1, 1) : 0);
        else send_stream(len, -1);
      end
      wait_drained();
    end
  endtask

  initial begin
    for (int i = 0; i < 256; i++) col_count[i] = '0;
    in_ch.valid            = 1'b0;
    in_ch.new_pixel        = '0;
    in_ch.background_pixel = '0;
    in_ch.frame_start      = 1'b0;
    out_ch.ready           = 1'b0;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    rst_n                  = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_register_defaults();
    test_directed_words();
    test_threshold_extremes();
    test_size_limits();
    test_midframe_reconfig();
    test_random_frames();

    // Every word has been accepted; wait for the last results and give the
    // block a few more cycles in which a stray result would be caught.
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (error_count == 0 && pending_blocks.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/bcd_pkg.sv
rtl/core/bcd_if.sv
rtl/core/bcd_regs.sv
rtl/core/bcd_front.sv
rtl/core/bcd_queue.sv
rtl/core/bcd_back.sv
rtl/core/block_change_detector_top.sv
bench/tb.sv
